FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the clocked checks of the clock unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

FILE: rtl/clwc_pkg.sv
// ----------------------------------------------------------------------------
// Clock unit package
// Types and constants shared by the clock, countdown and alarm unit.
// ----------------------------------------------------------------------------
package clwc_pkg;

    typedef enum logic [1:0] {
        MODE_TICK      = 2'd0,
        MODE_SET_CLOCK = 2'd1,
        MODE_START     = 2'd2,
        MODE_NOP       = 2'd3
    } t_mode;

    localparam logic [3:0] HOUR_FIRST   = 4'd1;
    localparam logic [3:0] HOUR_LAST    = 4'd12;
    localparam logic [5:0] UNIT_LAST    = 6'd59;
    localparam logic [6:0] CD_MIN_LAST  = 7'd99;
    localparam logic [7:0] ALERT_RESET  = 8'd5;

    typedef struct packed {
        t_mode      mode;
        logic [3:0] set_hours;
        logic [6:0] set_minutes;
        logic [5:0] set_seconds;
        logic       reminder_kind;
    } t_item;

    typedef struct packed {
        logic [3:0] clock_hours;
        logic [5:0] clock_minutes;
        logic [5:0] clock_seconds;
        logic [6:0] remaining_minutes;
        logic [5:0] remaining_seconds;
        logic       running_flag;
        logic       alerting_flag;
        logic       finished_flag;
        logic       alert_began;
    } t_result;

    typedef struct packed {
        logic [3:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [3:0] rem_hour;
        logic [6:0] rem_minutes;
        logic [5:0] rem_seconds;
        logic       rem_kind;
        logic       armed;
        logic       alerting;
        logic       done;
        logic [7:0] alert_left;
    } t_state;

endpackage

FILE: rtl/clwc_in_reg.sv
// ----------------------------------------------------------------------------
// Clock unit input register
// Captures one input beat and hands it to the core when the core advances.
// ----------------------------------------------------------------------------
module clwc_in_reg
    import clwc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  take;

    assign take    = i_valid && o_ready;
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: rtl/clwc_core.sv
// ----------------------------------------------------------------------------
// Clock unit core
// Clock and reminder state, one-pass update per beat, and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clwc_core
    import clwc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_alert_length,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_item      i_item,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_res
);

    t_state  r_st;
    t_state  n_st;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    adv;
    logic    began;
    logic    clock_ok;
    logic    fire_ok;

    assign o_ready = !r_out_valid || i_ready;
    assign adv     = i_valid && o_ready;
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    function automatic logic [3:0] limit_hour(input logic [3:0] h);
        if (h == 4'd0) begin
            return HOUR_FIRST;
        end else if (h > HOUR_LAST) begin
            return HOUR_LAST;
        end
        return h;
    endfunction

    function automatic logic [5:0] limit_unit(input logic [6:0] v);
        if (v > {1'b0, UNIT_LAST}) begin
            return UNIT_LAST;
        end
        return v[5:0];
    endfunction

    always_comb begin
        logic [6:0] dec_min;
        logic [5:0] dec_sec;
        n_st    = r_st;
        began   = 1'b0;
        dec_min = r_st.rem_minutes;
        dec_sec = r_st.rem_seconds;
        case (i_item.mode)
            MODE_TICK: begin
                if (r_st.seconds >= UNIT_LAST) begin
                    n_st.seconds = 6'd0;
                    if (r_st.minutes >= UNIT_LAST) begin
                        n_st.minutes = 6'd0;
                        n_st.hours   = (r_st.hours >= HOUR_LAST) ? HOUR_FIRST
                                                                 : r_st.hours + 4'd1;
                    end else begin
                        n_st.minutes = r_st.minutes + 6'd1;
                    end
                end else begin
                    n_st.seconds = r_st.seconds + 6'd1;
                end

                if (r_st.rem_seconds == 6'd0) begin
                    dec_min = r_st.rem_minutes - 7'd1;
                    dec_sec = UNIT_LAST;
                end else begin
                    dec_sec = r_st.rem_seconds - 6'd1;
                end

                if (!r_st.rem_kind && r_st.armed) begin
                    if (r_st.rem_minutes == 7'd0 && r_st.rem_seconds == 6'd0) begin
                        began = 1'b1;
                    end else begin
                        n_st.rem_minutes = dec_min;
                        n_st.rem_seconds = dec_sec;
                        began = (dec_min == 7'd0) && (dec_sec == 6'd0);
                    end
                end else if (r_st.rem_kind && r_st.armed &&
                             r_st.rem_minutes == {1'b0, n_st.minutes} &&
                             r_st.rem_hour == n_st.hours) begin
                    began = 1'b1;
                end else if (r_st.alerting) begin
                    if (r_st.alert_left <= 8'd1) begin
                        n_st.alert_left = 8'd0;
                        n_st.alerting   = 1'b0;
                        n_st.done       = 1'b1;
                    end else begin
                        n_st.alert_left = r_st.alert_left - 8'd1;
                    end
                end

                if (began) begin
                    n_st.armed      = 1'b0;
                    n_st.alerting   = 1'b1;
                    n_st.alert_left = i_alert_length;
                end
            end
            MODE_SET_CLOCK: begin
                n_st.hours   = limit_hour(i_item.set_hours);
                n_st.minutes = limit_unit(i_item.set_minutes);
                n_st.seconds = limit_unit({1'b0, i_item.set_seconds});
            end
            MODE_START: begin
                n_st.rem_kind = i_item.reminder_kind;
                if (!i_item.reminder_kind) begin
                    n_st.rem_minutes = (i_item.set_minutes > CD_MIN_LAST) ? CD_MIN_LAST
                                                                          : i_item.set_minutes;
                    n_st.rem_seconds = limit_unit({1'b0, i_item.set_seconds});
                end else begin
                    n_st.rem_hour    = limit_hour(i_item.set_hours);
                    n_st.rem_minutes = {1'b0, limit_unit(i_item.set_minutes)};
                    n_st.rem_seconds = 6'd0;
                end
                n_st.armed      = 1'b1;
                n_st.alerting   = 1'b0;
                n_st.done       = 1'b0;
                n_st.alert_left = 8'd0;
            end
            default: begin
                n_st = r_st;
            end
        endcase

        n_res.clock_hours       = n_st.hours;
        n_res.clock_minutes     = n_st.minutes;
        n_res.clock_seconds     = n_st.seconds;
        n_res.remaining_minutes = n_st.rem_minutes;
        n_res.remaining_seconds = n_st.rem_seconds;
        n_res.running_flag      = n_st.armed;
        n_res.alerting_flag     = n_st.alerting;
        n_res.finished_flag     = n_st.done;
        n_res.alert_began       = began;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.hours       <= HOUR_LAST;
            r_st.minutes     <= 6'd0;
            r_st.seconds     <= 6'd0;
            r_st.rem_hour    <= HOUR_LAST;
            r_st.rem_minutes <= 7'd0;
            r_st.rem_seconds <= 6'd0;
            r_st.rem_kind    <= 1'b0;
            r_st.armed       <= 1'b0;
            r_st.alerting    <= 1'b0;
            r_st.done        <= 1'b0;
            r_st.alert_left  <= 8'd0;
            r_out_valid      <= 1'b0;
        end else begin
            if (adv) begin
                r_st        <= n_st;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign clock_ok = (r_st.hours >= HOUR_FIRST) && (r_st.hours <= HOUR_LAST) &&
                      (r_st.minutes <= UNIT_LAST) && (r_st.seconds <= UNIT_LAST);
    assign fire_ok  = r_res.alerting_flag && !r_res.running_flag &&
                      (r_st.alert_left == i_alert_length);

    `ASSERT_NEVER(a_armed_alert, i_clk, i_rst_n, r_st.armed && r_st.alerting, "armed in alert")
    `ASSERT_NEVER(a_alert_done, i_clk, i_rst_n, r_st.alerting && r_st.done, "alert after finish")
    `ASSERT_CLK(a_clock_range, i_clk, i_rst_n, clock_ok, "clock time out of range")
    `ASSERT_CLK(a_began_alerts, i_clk, i_rst_n, adv && began |=> fire_ok, "alert start not loaded")

endmodule

FILE: rtl/clock_with_countdown_and_alarm_unit.sv
// ----------------------------------------------------------------------------
// Clock with countdown and alarm unit
// 12-hour clock with a countdown or alarm reminder and a timed alert.
// ----------------------------------------------------------------------------
// Accepts one beat per clock cycle on the input channel while o_ready is
// high, and returns one result beat for each: an input register, then a
// combinational update of the clock and reminder state that loads the
// result register. The state register is written with each accepted beat,
// so back-to-back beats see each other's effect. The alert length
// register is sampled when a reminder fires; write it only while idle.
module clock_with_countdown_and_alarm_unit
    import clwc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_mode,
    input  logic [3:0] i_set_hours,
    input  logic [6:0] i_set_minutes,
    input  logic [5:0] i_set_seconds,
    input  logic       i_reminder_kind,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_clock_hours,
    output logic [5:0] o_clock_minutes,
    output logic [5:0] o_clock_seconds,
    output logic [6:0] o_remaining_minutes,
    output logic [5:0] o_remaining_seconds,
    output logic       o_running_flag,
    output logic       o_alerting_flag,
    output logic       o_finished_flag,
    output logic       o_alert_began,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_alert_length
);

    logic [7:0] r_alert_length;
    t_item      in_item;
    t_item      core_item;
    logic       core_valid;
    logic       core_ready;
    t_result    res;

    assign in_item.mode          = t_mode'(i_mode);
    assign in_item.set_hours     = i_set_hours;
    assign in_item.set_minutes   = i_set_minutes;
    assign in_item.set_seconds   = i_set_seconds;
    assign in_item.reminder_kind = i_reminder_kind;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alert_length <= ALERT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_alert_length <= i_cfg_alert_length;
        end
    end

    clwc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (core_valid),
        .i_ready (core_ready),
        .o_item  (core_item)
    );

    clwc_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_alert_length (r_alert_length),
        .i_valid        (core_valid),
        .o_ready        (core_ready),
        .i_item         (core_item),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_res          (res)
    );

    assign o_clock_hours       = res.clock_hours;
    assign o_clock_minutes     = res.clock_minutes;
    assign o_clock_seconds     = res.clock_seconds;
    assign o_remaining_minutes = res.remaining_minutes;
    assign o_remaining_seconds = res.remaining_seconds;
    assign o_running_flag      = res.running_flag;
    assign o_alerting_flag     = res.alerting_flag;
    assign o_finished_flag     = res.finished_flag;
    assign o_alert_began       = res.alert_began;

endmodule
